FILE: rtl/core/erst_pkg.sv
// Shared types and constants of the error record store controller.
package erst_pkg;

  localparam int SlotCountDefault = 64;

  // Action codes written to the action register.
  localparam logic [4:0] ACT_BEGIN_WRITE  = 5'h00;
  localparam logic [4:0] ACT_BEGIN_READ   = 5'h01;
  localparam logic [4:0] ACT_BEGIN_CLEAR  = 5'h02;
  localparam logic [4:0] ACT_END          = 5'h03;
  localparam logic [4:0] ACT_SET_OFFSET   = 5'h04;
  localparam logic [4:0] ACT_EXECUTE      = 5'h05;
  localparam logic [4:0] ACT_CHECK_BUSY   = 5'h06;
  localparam logic [4:0] ACT_GET_STATUS   = 5'h07;
  localparam logic [4:0] ACT_GET_NEXT_ID  = 5'h08;
  localparam logic [4:0] ACT_SET_ID       = 5'h09;
  localparam logic [4:0] ACT_GET_COUNT    = 5'h0A;
  localparam logic [4:0] ACT_BEGIN_DUMMY  = 5'h0B;
  localparam logic [4:0] ACT_GET_BASE     = 5'h0D;
  localparam logic [4:0] ACT_GET_SIZE     = 5'h0E;
  localparam logic [4:0] ACT_GET_ATTR     = 5'h0F;
  localparam logic [4:0] ACT_GET_TIMINGS  = 5'h10;

  // Command status codes.
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NO_SPACE  = 3'd1;
  localparam logic [2:0] STS_FAILED    = 3'd3;
  localparam logic [2:0] STS_EMPTY     = 3'd4;
  localparam logic [2:0] STS_NOT_FOUND = 3'd5;

  // Copy command kinds.
  localparam logic [1:0] COPY_NONE    = 2'd0;
  localparam logic [1:0] COPY_TO_SLOT = 2'd1;
  localparam logic [1:0] COPY_TO_XCHG = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FIRST_SLOT  = 8'd0;
  localparam logic [7:0] CFG_SLOT_LIMIT  = 8'd1;
  localparam logic [7:0] CFG_BUF_SIZE    = 8'd2;
  localparam logic [7:0] CFG_LOG_BASE    = 8'd3;

  localparam logic [7:0]  EXEC_KEY   = 8'h9C;
  localparam logic [16:0] MIN_RECORD = 17'd128;
  localparam logic [63:0] ID_EMPTY   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TIMINGS    = {32'd100, 32'd10};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_RCHK   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    JOB_WRITE,
    JOB_READ_SEL,
    JOB_READ_FIND,
    JOB_READ_MISS,
    JOB_CLEAR,
    JOB_NEXT
  } job_t;

endpackage

FILE: rtl/core/error_record_store_controller.sv
// Error record store controller: action/value register interface over a slot map memory.
// Each bus request yields one result. A register read or write, or an action that needs no
// map lookup, passes through DECODE and DONE before its result is registered. Execute (write,
// read, clear) and get-next-id walk the slot map memory one slot per cycle; a read can chain
// up to three walks. The map memory's single read port sets that pace. Valid bits for each
// slot are flip-flops that reset clears at once, so the block is ready right after reset.
// Configuration writes are always taken (cfg_ready is high) and must only be issued while
// the block is idle.
module error_record_store_controller #(
  parameter int SLOT_COUNT = erst_pkg::SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_reg_address,
  input  logic        in_wide_access,
  input  logic [63:0] in_write_data,
  input  logic [31:0] in_xchg_length,
  input  logic [63:0] in_xchg_record_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_data,
  output logic [1:0]  out_copy_kind,
  output logic [5:0]  out_copy_slot,
  output logic [16:0] out_copy_length,
  output logic [16:0] out_copy_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = (IW + 1 > 7) ? IW + 1 : 7;

  // Configuration.
  logic [5:0]  first_slot_r;
  logic [6:0]  slot_limit_r;
  logic [16:0] buf_size_r;
  logic [63:0] log_base_r;

  // Architectural state.
  erst_pkg::state_t state_r, state_nxt;
  erst_pkg::job_t   job_r, job_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [4:0]  cur_op_r, cur_op_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [63:0] vr_r, vr_nxt;
  logic [16:0] off_r, off_nxt;
  logic [63:0] sel_r, sel_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;

  // Latched request.
  logic        kind_r;
  logic [3:0]  addr_r;
  logic        wide_r;
  logic [63:0] wdata_r;
  logic [31:0] xlen_r;
  logic [63:0] xid_r;

  // Map walk.
  logic [CW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic [6:0]    seen_r, seen_nxt;
  logic          free_found_r, free_found_nxt;
  logic [CW-1:0] free_idx_r, free_idx_nxt;
  logic [63:0]   tgt_r, tgt_nxt;

  // Map memory.
  logic [63:0] id_mem [SLOT_COUNT];
  logic [31:0] len_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [63:0] id_q_r;
  logic [31:0] len_q_r;
  logic        vld_q_r;
  logic          mem_we;
  logic [CW-1:0] mem_widx;
  logic          vld_clr;
  logic [IW-1:0] rd_addr;

  // Result.
  logic [63:0] res_data_r, res_data_nxt;
  logic [1:0]  res_ck_r, res_ck_nxt;
  logic [5:0]  res_slot_r, res_slot_nxt;
  logic [16:0] res_len_r, res_len_nxt;
  logic [16:0] res_off_r, res_off_nxt;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [1:0]  out_ck_r;
  logic [5:0]  out_slot_r;
  logic [16:0] out_len_r;
  logic [16:0] out_off_r;
  logic        out_load;

  // Combinational helpers.
  logic [CW-1:0] lo_w, hi_w, limit_w;
  logic        in_accept;
  logic        shift_hi, is_value;
  logic [63:0] data_w;
  logic [16:0] avail_w;
  logic        off_bad;
  logic        wr_bad;
  logic [63:0] eff_id;
  logic        issue, find_chk, find_hit, next_hit, scan_hit, scan_end;
  logic [CW-1:0] hit_cursor;
  logic [63:0] hit_id;

  assign limit_w = CW'(slot_limit_r);
  assign lo_w    = (first_slot_r == 6'd0) ? CW'(1) : CW'(first_slot_r);
  assign hi_w    = (limit_w > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : limit_w;

  assign in_stall  = (state_r != erst_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign shift_hi = !wide_r && addr_r[2];
  assign is_value = (addr_r == 4'd8) || (addr_r == 4'd12);
  assign data_w   = wide_r ? wdata_r : {32'd0, wdata_r[31:0]};

  assign avail_w = buf_size_r - off_r;
  assign off_bad = (buf_size_r < erst_pkg::MIN_RECORD) ||
                   (off_r > buf_size_r - erst_pkg::MIN_RECORD);
  assign wr_bad  = off_bad || (xlen_r < 32'(erst_pkg::MIN_RECORD)) ||
                   (xlen_r > 32'(avail_w)) || (xid_r == 64'd0) ||
                   (xid_r == erst_pkg::ID_EMPTY);

  // One slot is read per cycle; its data is checked the cycle after.
  assign rd_addr  = scan_cnt_r[IW-1:0];
  assign eff_id   = vld_q_r ? id_q_r : 64'd0;
  assign issue    = (scan_cnt_r < hi_w);
  assign find_chk = pend_r && (seen_r < count_r);
  assign find_hit = find_chk && (eff_id == tgt_r);
  assign next_hit = pend_r && (eff_id != 64'd0);
  assign scan_end = !pend_r && !issue;
  assign scan_hit = (job_r == erst_pkg::JOB_READ_SEL || job_r == erst_pkg::JOB_READ_MISS ||
                     job_r == erst_pkg::JOB_NEXT) ? next_hit : find_hit;
  assign hit_cursor = scan_hit ? pend_idx_r + CW'(1) : lo_w;
  assign hit_id     = scan_hit ? eff_id : erst_pkg::ID_EMPTY;

  assign out_load = (state_r == erst_pkg::S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    count_nxt      = count_r;
    cur_op_nxt     = cur_op_r;
    status_nxt     = status_r;
    vr_nxt         = vr_r;
    off_nxt        = off_r;
    sel_nxt        = sel_r;
    cursor_nxt     = cursor_r;
    scan_cnt_nxt   = scan_cnt_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    seen_nxt       = seen_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    tgt_nxt        = tgt_r;
    res_data_nxt   = res_data_r;
    res_ck_nxt     = res_ck_r;
    res_slot_nxt   = res_slot_r;
    res_len_nxt    = res_len_r;
    res_off_nxt    = res_off_r;
    mem_we         = 1'b0;
    mem_widx       = pend_idx_r;
    vld_clr        = 1'b0;

    case (state_r)
      erst_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = erst_pkg::S_DECODE;
        end
      end

      erst_pkg::S_DECODE: begin
        res_data_nxt = 64'd0;
        res_ck_nxt   = erst_pkg::COPY_NONE;
        res_slot_nxt = 6'd0;
        res_len_nxt  = 17'd0;
        res_off_nxt  = 17'd0;
        state_nxt    = erst_pkg::S_DONE;
        scan_cnt_nxt   = lo_w;
        seen_nxt       = 7'd0;
        free_found_nxt = 1'b0;
        if (!kind_r) begin
          if (is_value) begin
            if (shift_hi) begin
              res_data_nxt = {32'd0, vr_r[63:32]};
            end else if (wide_r) begin
              res_data_nxt = vr_r;
            end else begin
              res_data_nxt = {32'd0, vr_r[31:0]};
            end
          end
        end else if (is_value) begin
          if (shift_hi) begin
            vr_nxt = {data_w[31:0], vr_r[31:0]};
          end else if (wide_r) begin
            vr_nxt = data_w;
          end else begin
            vr_nxt = {vr_r[63:32], data_w[31:0]};
          end
        end else if (addr_r == 4'd0 && data_w[63:5] == 59'd0) begin
          case (data_w[4:0])
            erst_pkg::ACT_BEGIN_WRITE, erst_pkg::ACT_BEGIN_READ, erst_pkg::ACT_BEGIN_CLEAR,
            erst_pkg::ACT_END, erst_pkg::ACT_BEGIN_DUMMY: begin
              cur_op_nxt = data_w[4:0];
            end
            erst_pkg::ACT_SET_OFFSET: begin
              off_nxt = (vr_r[31:17] != 15'd0) ? 17'h1FFFF : vr_r[16:0];
            end
            erst_pkg::ACT_EXECUTE: begin
              if (vr_r[7:0] == erst_pkg::EXEC_KEY) begin
                case (cur_op_r)
                  erst_pkg::ACT_BEGIN_WRITE: begin
                    if (wr_bad) begin
                      status_nxt = erst_pkg::STS_FAILED;
                    end else begin
                      tgt_nxt   = xid_r;
                      job_nxt   = erst_pkg::JOB_WRITE;
                      state_nxt = erst_pkg::S_SCAN;
                    end
                  end
                  erst_pkg::ACT_BEGIN_READ: begin
                    if (count_r == 7'd0) begin
                      status_nxt = erst_pkg::STS_EMPTY;
                    end else if (sel_r == 64'd0) begin
                      job_nxt   = erst_pkg::JOB_READ_SEL;
                      state_nxt = erst_pkg::S_SCAN;
                    end else begin
                      state_nxt = erst_pkg::S_RCHK;
                    end
                  end
                  erst_pkg::ACT_BEGIN_CLEAR: begin
                    if (sel_r == 64'd0 || sel_r == erst_pkg::ID_EMPTY) begin
                      status_nxt = erst_pkg::STS_FAILED;
                    end else begin
                      tgt_nxt   = sel_r;
                      job_nxt   = erst_pkg::JOB_CLEAR;
                      state_nxt = erst_pkg::S_SCAN;
                    end
                  end
                  erst_pkg::ACT_END, erst_pkg::ACT_BEGIN_DUMMY: begin
                    status_nxt = erst_pkg::STS_OK;
                  end
                  default: begin
                    status_nxt = erst_pkg::STS_FAILED;
                  end
                endcase
              end
            end
            erst_pkg::ACT_CHECK_BUSY: vr_nxt = 64'd0;
            erst_pkg::ACT_GET_STATUS: vr_nxt = {61'd0, status_r};
            erst_pkg::ACT_GET_NEXT_ID: begin
              status_nxt = erst_pkg::STS_OK;
              if (count_r == 7'd0) begin
                cursor_nxt = lo_w;
                vr_nxt     = erst_pkg::ID_EMPTY;
              end else begin
                scan_cnt_nxt = cursor_r;
                job_nxt      = erst_pkg::JOB_NEXT;
                state_nxt    = erst_pkg::S_SCAN;
              end
            end
            erst_pkg::ACT_SET_ID:      sel_nxt = vr_r;
            erst_pkg::ACT_GET_COUNT:   vr_nxt  = {57'd0, count_r};
            erst_pkg::ACT_GET_BASE:    vr_nxt  = log_base_r;
            erst_pkg::ACT_GET_SIZE:    vr_nxt  = {47'd0, buf_size_r};
            erst_pkg::ACT_GET_ATTR:    vr_nxt  = 64'd0;
            erst_pkg::ACT_GET_TIMINGS: vr_nxt  = erst_pkg::TIMINGS;
            default: begin
            end
          endcase
        end
      end

      erst_pkg::S_RCHK: begin
        if (sel_r == erst_pkg::ID_EMPTY || off_bad) begin
          status_nxt = erst_pkg::STS_FAILED;
          state_nxt  = erst_pkg::S_DONE;
        end else begin
          tgt_nxt        = sel_r;
          job_nxt        = erst_pkg::JOB_READ_FIND;
          scan_cnt_nxt   = lo_w;
          seen_nxt       = 7'd0;
          free_found_nxt = 1'b0;
          state_nxt      = erst_pkg::S_SCAN;
        end
      end

      erst_pkg::S_SCAN: begin
        pend_nxt     = issue;
        pend_idx_nxt = scan_cnt_r;
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end
        if (find_chk && eff_id != 64'd0) begin
          seen_nxt = seen_r + 7'd1;
        end
        if (pend_r && eff_id == 64'd0 && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = pend_idx_r;
        end
        if (scan_hit || scan_end) begin
          pend_nxt  = 1'b0;
          state_nxt = erst_pkg::S_DONE;
          case (job_r)
            erst_pkg::JOB_WRITE: begin
              if (scan_hit || free_found_r) begin
                mem_we     = 1'b1;
                mem_widx   = scan_hit ? pend_idx_r : free_idx_r;
                status_nxt = erst_pkg::STS_OK;
                if (!scan_hit && count_r != 7'd127) begin
                  count_nxt = count_r + 7'd1;
                end
                res_ck_nxt   = erst_pkg::COPY_TO_SLOT;
                res_slot_nxt = 6'(mem_widx);
                res_len_nxt  = xlen_r[16:0];
                res_off_nxt  = off_r;
              end else begin
                status_nxt = erst_pkg::STS_NO_SPACE;
              end
            end
            erst_pkg::JOB_READ_SEL: begin
              sel_nxt    = hit_id;
              cursor_nxt = hit_cursor;
              state_nxt  = erst_pkg::S_RCHK;
            end
            erst_pkg::JOB_READ_FIND: begin
              if (scan_hit) begin
                if (len_q_r < 32'(erst_pkg::MIN_RECORD) || len_q_r > 32'(avail_w)) begin
                  status_nxt = erst_pkg::STS_FAILED;
                end else begin
                  status_nxt   = erst_pkg::STS_OK;
                  res_ck_nxt   = erst_pkg::COPY_TO_XCHG;
                  res_slot_nxt = 6'(pend_idx_r);
                  res_len_nxt  = len_q_r[16:0];
                  res_off_nxt  = off_r;
                end
              end else begin
                // The selected record is gone: restart iteration from the first slot.
                job_nxt      = erst_pkg::JOB_READ_MISS;
                scan_cnt_nxt = lo_w;
                state_nxt    = erst_pkg::S_SCAN;
              end
            end
            erst_pkg::JOB_READ_MISS: begin
              sel_nxt    = hit_id;
              cursor_nxt = hit_cursor;
              status_nxt = erst_pkg::STS_NOT_FOUND;
            end
            erst_pkg::JOB_CLEAR: begin
              if (scan_hit) begin
                vld_clr    = 1'b1;
                status_nxt = erst_pkg::STS_OK;
                if (count_r != 7'd0) begin
                  count_nxt = count_r - 7'd1;
                end
              end else begin
                status_nxt = erst_pkg::STS_NOT_FOUND;
              end
            end
            erst_pkg::JOB_NEXT: begin
              vr_nxt     = hit_id;
              cursor_nxt = hit_cursor;
            end
            default: begin
            end
          endcase
        end
      end

      erst_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = erst_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = erst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[mem_widx[IW-1:0]]  <= tgt_r;
      len_mem[mem_widx[IW-1:0]] <= xlen_r;
    end
    id_q_r  <= id_mem[rd_addr];
    len_q_r <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= valid_r[rd_addr];
      if (mem_we) begin
        valid_r[mem_widx[IW-1:0]] <= 1'b1;
      end
      if (vld_clr) begin
        valid_r[pend_idx_r[IW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_slot_r  <= 6'd1;
      slot_limit_r  <= 7'd64;
      buf_size_r    <= 17'd8192;
      log_base_r    <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        erst_pkg::CFG_FIRST_SLOT:  first_slot_r  <= cfg_data[5:0];
        erst_pkg::CFG_SLOT_LIMIT:  slot_limit_r  <= cfg_data[6:0];
        erst_pkg::CFG_BUF_SIZE:    buf_size_r    <= cfg_data[16:0];
        erst_pkg::CFG_LOG_BASE:    log_base_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r  <= in_kind;
      addr_r  <= in_reg_address;
      wide_r  <= in_wide_access;
      wdata_r <= in_write_data;
      xlen_r  <= in_xchg_length;
      xid_r   <= in_xchg_record_id;
    end
    scan_cnt_r   <= scan_cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    seen_r       <= seen_nxt;
    free_idx_r   <= free_idx_nxt;
    tgt_r        <= tgt_nxt;
    job_r        <= job_nxt;
    res_data_r   <= res_data_nxt;
    res_ck_r     <= res_ck_nxt;
    res_slot_r   <= res_slot_nxt;
    res_len_r    <= res_len_nxt;
    res_off_r    <= res_off_nxt;
    if (out_load) begin
      out_data_r <= res_data_r;
      out_ck_r   <= res_ck_r;
      out_slot_r <= res_slot_r;
      out_len_r  <= res_len_r;
      out_off_r  <= res_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= erst_pkg::S_IDLE;
      count_r      <= 7'd0;
      cur_op_r     <= erst_pkg::ACT_BEGIN_WRITE;
      status_r     <= erst_pkg::STS_OK;
      vr_r         <= 64'd0;
      off_r        <= 17'd0;
      sel_r        <= 64'd0;
      cursor_r     <= CW'(1);
      pend_r       <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cur_op_r     <= cur_op_nxt;
      status_r     <= status_nxt;
      vr_r         <= vr_nxt;
      off_r        <= off_nxt;
      sel_r        <= sel_nxt;
      cursor_r     <= cursor_nxt;
      pend_r       <= pend_nxt;
      free_found_r <= free_found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_copy_kind   = out_ck_r;
  assign out_copy_slot   = out_slot_r;
  assign out_copy_length = out_len_r;
  assign out_copy_offset = out_off_r;

endmodule

FILE: bench/tb_error_record_store_controller.sv
// Testbench for error_record_store_controller: directed and random bus requests checked by a scoreboard.
module tb_error_record_store_controller;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  copy_kind;
    logic [5:0]  copy_slot;
    logic [16:0] copy_length;
    logic [16:0] copy_offset;
  } erst_result_t;

  class erst_scoreboard;
    logic [5:0]  first_slot;
    logic [6:0]  slot_limit;
    logic [16:0] buf_size;
    logic [63:0] log_base;
    logic [63:0] slot_ids [erst_pkg::SlotCountDefault];
    logic [31:0] slot_lengths [erst_pkg::SlotCountDefault];
    logic [6:0]  stored_count;
    logic [4:0]  current_op;
    logic [2:0]  cmd_status;
    logic [63:0] value_reg;
    logic [16:0] offset_reg;
    logic [63:0] selected_id;
    int          scan_cursor;
    erst_result_t pending_q[$];
    int          errors;

    function new();
      first_slot = 1;
      slot_limit = 64;
      buf_size = 8192;
      log_base = '0;
      foreach (slot_ids[i]) begin
        slot_ids[i] = '0;
        slot_lengths[i] = '0;
      end
      stored_count = 0;
      current_op = erst_pkg::ACT_BEGIN_WRITE;
      cmd_status = erst_pkg::STS_OK;
      value_reg = '0;
      offset_reg = '0;
      selected_id = '0;
      scan_cursor = 1;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void configure(logic [7:0] idx, logic [63:0] data);
      case (idx)
        erst_pkg::CFG_FIRST_SLOT: first_slot = data[5:0];
        erst_pkg::CFG_SLOT_LIMIT: slot_limit = data[6:0];
        erst_pkg::CFG_BUF_SIZE:   buf_size = data[16:0];
        erst_pkg::CFG_LOG_BASE:   log_base = data;
        default: ;
      endcase
    endfunction

    function int lo_slot();
      return (first_slot == 0) ? 1 : int'(first_slot);
    endfunction

    function int hi_slot();
      return (slot_limit > erst_pkg::SlotCountDefault) ? erst_pkg::SlotCountDefault :
                                                          int'(slot_limit);
    endfunction

    function int find_slot(logic [63:0] id);
      int seen;
      seen = 0;
      if (id == 0) return 0;
      for (int i = lo_slot(); i < hi_slot() && seen < stored_count; i++) begin
        if (slot_ids[i] == id) return i;
        if (slot_ids[i] != 0) seen++;
      end
      return 0;
    endfunction

    function int free_slot();
      for (int i = lo_slot(); i < hi_slot(); i++)
        if (slot_ids[i] == 0) return i;
      return 0;
    endfunction

    function logic [63:0] walk_next(bit restart);
      if (restart) scan_cursor = lo_slot();
      if (stored_count != 0) begin
        for (int i = scan_cursor; i < hi_slot(); i++) begin
          if (slot_ids[i] != 0) begin
            scan_cursor = i + 1;
            return slot_ids[i];
          end
        end
      end
      scan_cursor = lo_slot();
      return erst_pkg::ID_EMPTY;
    endfunction

    function bit offset_bad();
      return buf_size < erst_pkg::MIN_RECORD || offset_reg > buf_size - erst_pkg::MIN_RECORD;
    endfunction

    function logic [2:0] store_record(logic [31:0] len, logic [63:0] id,
                                      inout erst_result_t res);
      int idx;
      bit fresh;
      fresh = 0;
      if (offset_bad()) return erst_pkg::STS_FAILED;
      if (len < erst_pkg::MIN_RECORD || len > 32'(buf_size - offset_reg))
        return erst_pkg::STS_FAILED;
      if (id == 0 || id == erst_pkg::ID_EMPTY) return erst_pkg::STS_FAILED;
      idx = find_slot(id);
      if (idx == 0) begin
        idx = free_slot();
        if (idx == 0) return erst_pkg::STS_NO_SPACE;
        fresh = 1;
      end
      if (fresh && stored_count < 127) stored_count++;
      slot_ids[idx] = id;
      slot_lengths[idx] = len;
      res.copy_kind = erst_pkg::COPY_TO_SLOT;
      res.copy_slot = idx[5:0];
      res.copy_length = len[16:0];
      res.copy_offset = offset_reg;
      return erst_pkg::STS_OK;
    endfunction

    function logic [2:0] fetch_record(inout erst_result_t res);
      int idx;
      logic [31:0] len;
      if (stored_count == 0) return erst_pkg::STS_EMPTY;
      if (selected_id == 0) selected_id = walk_next(1);
      if (selected_id == erst_pkg::ID_EMPTY) return erst_pkg::STS_FAILED;
      if (offset_bad()) return erst_pkg::STS_FAILED;
      idx = find_slot(selected_id);
      if (idx == 0) begin
        selected_id = walk_next(1);
        return erst_pkg::STS_NOT_FOUND;
      end
      len = slot_lengths[idx];
      if (len < erst_pkg::MIN_RECORD || len > 32'(buf_size - offset_reg))
        return erst_pkg::STS_FAILED;
      res.copy_kind = erst_pkg::COPY_TO_XCHG;
      res.copy_slot = idx[5:0];
      res.copy_length = len[16:0];
      res.copy_offset = offset_reg;
      return erst_pkg::STS_OK;
    endfunction

    function logic [2:0] clear_record();
      int idx;
      if (selected_id == 0 || selected_id == erst_pkg::ID_EMPTY) return erst_pkg::STS_FAILED;
      idx = find_slot(selected_id);
      if (idx == 0) return erst_pkg::STS_NOT_FOUND;
      slot_ids[idx] = 0;
      if (stored_count != 0) stored_count--;
      return erst_pkg::STS_OK;
    endfunction

    function void note_request(logic kind, logic [3:0] addr, logic wide, logic [63:0] wdata,
                               logic [31:0] xlen, logic [63:0] xid);
      erst_result_t res;
      logic [63:0] data, mask;
      int shift;
      res = '0;
      data = wide ? wdata : {32'd0, wdata[31:0]};
      mask = wide ? '1 : 64'hFFFF_FFFF;
      shift = (!wide && addr[2]) ? 32 : 0;
      if (kind) begin
        if (addr == 8 || addr == 12) begin
          value_reg = (value_reg & ~(mask << shift)) | (data << shift);
        end else if (addr == 0 && data[63:5] == 0) begin
          case (data[4:0])
            erst_pkg::ACT_BEGIN_WRITE, erst_pkg::ACT_BEGIN_READ, erst_pkg::ACT_BEGIN_CLEAR,
            erst_pkg::ACT_END, erst_pkg::ACT_BEGIN_DUMMY:
              current_op = data[4:0];
            erst_pkg::ACT_SET_OFFSET:
              offset_reg = (value_reg[31:0] > 32'h1FFFF) ? 17'h1FFFF : value_reg[16:0];
            erst_pkg::ACT_EXECUTE: begin
              if (value_reg[7:0] == erst_pkg::EXEC_KEY) begin
                case (current_op)
                  erst_pkg::ACT_BEGIN_WRITE: cmd_status = store_record(xlen, xid, res);
                  erst_pkg::ACT_BEGIN_READ:  cmd_status = fetch_record(res);
                  erst_pkg::ACT_BEGIN_CLEAR: cmd_status = clear_record();
                  default:                   cmd_status = erst_pkg::STS_OK;
                endcase
              end
            end
            erst_pkg::ACT_CHECK_BUSY:  value_reg = 0;
            erst_pkg::ACT_GET_STATUS:  value_reg = 64'(cmd_status);
            erst_pkg::ACT_GET_NEXT_ID: begin
              value_reg = walk_next(0);
              cmd_status = erst_pkg::STS_OK;
            end
            erst_pkg::ACT_SET_ID:      selected_id = value_reg;
            erst_pkg::ACT_GET_COUNT:   value_reg = 64'(stored_count);
            erst_pkg::ACT_GET_BASE:    value_reg = log_base;
            erst_pkg::ACT_GET_SIZE:    value_reg = 64'(buf_size);
            erst_pkg::ACT_GET_ATTR:    value_reg = 0;
            erst_pkg::ACT_GET_TIMINGS: value_reg = erst_pkg::TIMINGS;
            default: ;
          endcase
        end
      end else if (addr == 8 || addr == 12) begin
        res.read_data = (value_reg >> shift) & mask;
      end
      pending_q.push_back(res);
    endfunction

    task check_result(erst_result_t got);
      erst_result_t want;
      if (pending_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_q.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
        if (got.copy_kind !== want.copy_kind)
          report($sformatf("copy_kind %0d, expected %0d", got.copy_kind, want.copy_kind));
        if (got.copy_slot !== want.copy_slot)
          report($sformatf("copy_slot %0d, expected %0d", got.copy_slot, want.copy_slot));
        if (got.copy_length !== want.copy_length)
          report($sformatf("copy_length %0d, expected %0d",
                           got.copy_length, want.copy_length));
        if (got.copy_offset !== want.copy_offset)
          report($sformatf("copy_offset %0d, expected %0d",
                           got.copy_offset, want.copy_offset));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_kind = 0;
  logic [3:0]  in_reg_address = 0;
  logic        in_wide_access = 0;
  logic [63:0] in_write_data = 0;
  logic [31:0] in_xchg_length = 0;
  logic [63:0] in_xchg_record_id = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] out_read_data;
  logic [1:0]  out_copy_kind;
  logic [5:0]  out_copy_slot;
  logic [16:0] out_copy_length;
  logic [16:0] out_copy_offset;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 0;
  logic [63:0] cfg_data = 0;

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 400;

  erst_scoreboard sb = new();
  int request_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [63:0] id_pool [8];

  error_record_store_controller dut (.*);

  always #5 clk = ~clk;

  // Receiver side: random stalls, plus a long hold whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HoldCycles;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({out_read_data, out_copy_kind, out_copy_slot,
                         out_copy_length, out_copy_offset});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("timeout: no request or result moved for %0d cycles", IdleLimit);
        $display("tb_error_record_store_controller: done, errors");
        $finish;
      end
    end
  end

  task send(logic kind, logic [3:0] addr, logic wide, logic [63:0] data,
            logic [31:0] xlen, logic [63:0] xid);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_reg_address <= addr;
    in_wide_access <= wide;
    in_write_data <= data;
    in_xchg_length <= xlen;
    in_xchg_record_id <= xid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(kind, addr, wide, data, xlen, xid);
    request_count++;
  endtask

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task set_value(logic [63:0] v);
    send(1, 4'd8, 1, v, $urandom, rand64());
  endtask

  task action(logic [4:0] code);
    send(1, 4'd0, 1, 64'(code), $urandom, rand64());
  endtask

  task read_value();
    send(0, 4'd8, 1, rand64(), $urandom, rand64());
  endtask

  task execute(logic [31:0] xlen, logic [63:0] xid);
    set_value(64'(erst_pkg::EXEC_KEY));
    send(1, 4'd0, 1, 64'(erst_pkg::ACT_EXECUTE), xlen, xid);
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task write_cfg(logic [7:0] idx, logic [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.configure(idx, data);
    @(posedge clk);
  endtask

  task store_seq(logic [63:0] id);
    logic [31:0] len;
    case ($urandom_range(9))
      0:       set_value(rand64());
      1, 2:    set_value(64'($urandom_range(sb.buf_size)));
      default: set_value(64'($urandom_range(3) * 256));
    endcase
    action(erst_pkg::ACT_SET_OFFSET);
    action(erst_pkg::ACT_BEGIN_WRITE);
    case ($urandom_range(9))
      0:       len = $urandom;
      1:       len = 128;
      default: len = $urandom_range(128, 2048);
    endcase
    execute(len, id);
    action(erst_pkg::ACT_GET_STATUS);
    read_value();
  endtask

  task select_seq(logic [4:0] op, logic [63:0] id);
    set_value(id);
    action(erst_pkg::ACT_SET_ID);
    if ($urandom_range(3) == 0) begin
      set_value(64'($urandom_range(8192)));
      action(erst_pkg::ACT_SET_OFFSET);
    end
    action(op);
    execute($urandom, rand64());
    action(erst_pkg::ACT_GET_STATUS);
    read_value();
  endtask

  task random_seq();
    logic [63:0] id;
    logic [4:0] code;
    id = ($urandom_range(9) == 0) ? rand64() : id_pool[$urandom_range(7)];
    case ($urandom_range(11))
      0, 1, 2, 3: store_seq(id);
      4, 5:       select_seq(erst_pkg::ACT_BEGIN_READ,
                             ($urandom_range(4) == 0) ? 64'd0 : id);
      6:          select_seq(erst_pkg::ACT_BEGIN_CLEAR, id);
      7: begin
        action(erst_pkg::ACT_GET_NEXT_ID);
        send(0, 4'd8, 0, rand64(), $urandom, rand64());
        send(0, 4'd12, 0, rand64(), $urandom, rand64());
      end
      8: begin
        code = 5'($urandom_range(erst_pkg::ACT_GET_TIMINGS));
        action(code);
        read_value();
      end
      default: send(1'($urandom_range(1)), 4'($urandom), 1'($urandom_range(1)), rand64(),
                    $urandom, rand64());
    endcase
  endtask

  task set_pace(int phase);
    case (phase % 4)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 74; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 74; end
      default: begin sender_idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = rand64();
    id_pool[0] = 64'd1;
    id_pool[1] = erst_pkg::ID_EMPTY - 1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part under the reset configuration.
    execute(128, id_pool[2]);                  // first execute is a write: begin write is the default
    action(erst_pkg::ACT_BEGIN_READ);
    execute(128, id_pool[2]);
    action(erst_pkg::ACT_GET_STATUS);
    read_value();
    set_value(64'h1234_5678_0002_0000);        // offset latch saturates
    action(erst_pkg::ACT_SET_OFFSET);
    set_value(64'(erst_pkg::EXEC_KEY) | 64'hFF00);  // key in low byte alone is what counts
    send(1, 4'd12, 0, 64'hDEAD_BEEF_0000_0001, 0, 0);  // narrow write to the high half
    send(0, 4'd12, 0, 0, 0, 0);
    send(0, 4'd4, 1, 0, 0, 0);
    send(1, 4'd4, 1, 64'(erst_pkg::ACT_GET_TIMINGS), 0, 0);  // ignored address
    send(1, 4'd0, 1, 64'h0C, 0, 0);                     // reserved action
    send(1, 4'd0, 1, 64'h1_0000_0010, 0, 0);            // unknown wide action
    send(1, 4'd0, 0, 64'hFFFF_FFFF_0000_0010, 0, 0);    // narrow: timings
    read_value();
    set_value(0);
    action(erst_pkg::ACT_EXECUTE);                       // no key: ignored
    for (int c = erst_pkg::ACT_CHECK_BUSY; c <= erst_pkg::ACT_GET_TIMINGS; c++) begin
      action(5'(c));
      read_value();
    end
    store_seq(erst_pkg::ID_EMPTY);
    store_seq(0);
    store_seq(id_pool[0]);
    select_seq(erst_pkg::ACT_BEGIN_READ, id_pool[0]);
    select_seq(erst_pkg::ACT_BEGIN_CLEAR, id_pool[0]);
    select_seq(erst_pkg::ACT_BEGIN_CLEAR, id_pool[0]);
    action(erst_pkg::ACT_BEGIN_DUMMY);
    execute(0, 0);
    action(erst_pkg::ACT_END);
    execute(0, 0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: begin
          write_cfg(erst_pkg::CFG_FIRST_SLOT, 1);
          write_cfg(erst_pkg::CFG_SLOT_LIMIT, 64);
          write_cfg(erst_pkg::CFG_BUF_SIZE, 65536);
          write_cfg(erst_pkg::CFG_LOG_BASE, '1);
        end
        2: begin
          write_cfg(erst_pkg::CFG_FIRST_SLOT, 60);
          write_cfg(erst_pkg::CFG_BUF_SIZE, 4096);
          write_cfg(erst_pkg::CFG_LOG_BASE, rand64());
        end
        3: write_cfg(erst_pkg::CFG_SLOT_LIMIT, 2);
        4: begin
          write_cfg(erst_pkg::CFG_FIRST_SLOT, 63);
          write_cfg(erst_pkg::CFG_SLOT_LIMIT, 64);
        end
        5: begin
          write_cfg(erst_pkg::CFG_FIRST_SLOT, 5);
          write_cfg(erst_pkg::CFG_SLOT_LIMIT, 20);
          write_cfg(erst_pkg::CFG_BUF_SIZE, 8192);
        end
        6: begin
          write_cfg(erst_pkg::CFG_FIRST_SLOT, 1);
          write_cfg(erst_pkg::CFG_SLOT_LIMIT, 64);
          write_cfg(erst_pkg::CFG_LOG_BASE, 0);
        end
        default: ;
      endcase
      set_pace(phase);
      // The receiver holds off for a long stretch while requests keep coming.
      if (phase == 1) hold_token++;
      while (request_count < 140 + (phase + 1) * 140) begin
        random_seq();
        if ($urandom_range(40) == 0) drain();
      end
      drain();
    end

    if (sb.pending_q.size() != 0) sb.report("results still expected at the end");
    if (sb.errors == 0)
      $display("tb_error_record_store_controller: done, clean");
    else
      $display("tb_error_record_store_controller: done, errors");
    $finish;
  end
endmodule
